FILE: sv/rpnsc_pkg.sv
package rpnsc_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [2:0] req_code_t;
	typedef logic [2:0] stat_code_t;

	// Request codes.
	localparam req_code_t REQ_PUSH = 3'd0;
	localparam req_code_t REQ_ADD  = 3'd1;
	localparam req_code_t REQ_SUB  = 3'd2;
	localparam req_code_t REQ_MUL  = 3'd3;
	localparam req_code_t REQ_DIV  = 3'd4;
	localparam req_code_t REQ_SWAP = 3'd5;
	localparam req_code_t REQ_DROP = 3'd6;
	localparam req_code_t REQ_PEEK = 3'd7;

	// Status codes.
	localparam stat_code_t ST_OK    = 3'd0;
	localparam stat_code_t ST_FEW   = 3'd1;
	localparam stat_code_t ST_DIVZ  = 3'd2;
	localparam stat_code_t ST_FULL  = 3'd3;
	localparam stat_code_t ST_EMPTY = 3'd4;

	// Command from the sequencer to the arithmetic unit.
	typedef struct packed {
		logic      start;
		req_code_t op;
	} alu_req_t;

endpackage

FILE: sv/rpn_stack_calculator_unit.sv
// Reverse-Polish integer calculator over a bounded stack of 32-bit signed values.
// Requests arrive on the input channel (in_valid/in_ready, req_type, operand) and
// each one produces exactly one result transfer on the output channel
// (out_valid/out_ready, top_value, depth, status).
// The block handles one request at a time: in_ready is high only while the
// sequencer is idle. Push, drop, peek and every error case go from the read
// state straight to the output state; swap passes through a second write state,
// add and subtract through the arithmetic unit, and multiply and divide through
// the 32 single-bit steps of the shared shift-add / restoring-divide unit.
// The stack lives in a memory with two registered read ports and one write port,
// so each request first passes a read state that fetches the top two entries.
// The result sits in an output register, so a new request is taken while a
// finished result still waits. If the receiver stalls, the following request
// completes its work and then waits until the output register frees up.
// Reset clears the stack count, the sequencer and out_valid; stack contents are
// not cleared and are never read before they are written.
module rpn_stack_calculator_unit #(
	parameter int STACK_DEPTH = rpnsc_pkg::STACK_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  rpnsc_pkg::req_code_t   req_type,
	input  rpnsc_pkg::word_t       operand,
	output logic                   out_valid,
	input  logic                   out_ready,
	output rpnsc_pkg::word_t       top_value,
	output logic [4:0]             depth,
	output rpnsc_pkg::stat_code_t  status
);
	import rpnsc_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);
	localparam logic [CW-1:0] TWO_CNT  = CW'(2);

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_SWAP = 3'd2;
	localparam logic [2:0] S_ALU  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic          out_valid_q;

	req_code_t     req_q;
	word_t         opnd_q;
	word_t         res_top_q;
	stat_code_t    res_stat_q;
	word_t         top_q;
	logic [4:0]    depth_q;
	stat_code_t    status_q;

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [AW-1:0] addr_top;
	logic [AW-1:0] addr_next;
	word_t         rd_top;
	word_t         rd_next;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	word_t         wr_data;

	logic          cnt_zero;
	logic          cnt_few;
	logic          cnt_full;
	logic          is_arith;
	logic          arith_go;
	logic          out_free;

	alu_req_t      alu_req;
	logic          alu_done;
	word_t         alu_result;

	assign cnt_m1    = count_q - ONE_CNT;
	assign cnt_m2    = count_q - TWO_CNT;
	assign addr_top  = cnt_m1[AW-1:0];
	assign addr_next = cnt_m2[AW-1:0];

	assign cnt_zero = (count_q == '0);
	assign cnt_few  = (count_q < TWO_CNT);
	assign cnt_full = (count_q == FULL_CNT);

	assign is_arith = (req_q == REQ_ADD) || (req_q == REQ_SUB) ||
	                  (req_q == REQ_MUL) || (req_q == REQ_DIV);
	// An arithmetic request runs only with two operands and, for divide, a nonzero divisor.
	assign arith_go = is_arith && !cnt_few && !((req_q == REQ_DIV) && (rd_top == '0));

	assign alu_req.start = (state_q == S_READ) && arith_go;
	assign alu_req.op    = req_q;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	rpnsc_stack #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_stack (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (addr_top),
		.rd_addr_b (addr_next),
		.rd_data_a (rd_top),
		.rd_data_b (rd_next)
	);

	rpnsc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (rd_next),
		.b      (rd_top),
		.done   (alu_done),
		.result (alu_result)
	);

	// Memory write port: push into the free slot, the two halves of a swap,
	// or an arithmetic result over the left operand.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_top;
		wr_data = rd_next;
		case (state_q)
			S_READ: begin
				if (req_q == REQ_PUSH && !cnt_full) begin
					wr_en   = 1'b1;
					wr_addr = count_q[AW-1:0];
					wr_data = opnd_q;
				end else if (req_q == REQ_SWAP && !cnt_few) begin
					wr_en   = 1'b1;
					wr_addr = addr_top;
					wr_data = rd_next;
				end
			end
			S_SWAP: begin
				wr_en   = 1'b1;
				wr_addr = addr_next;
				wr_data = rd_top;
			end
			S_ALU: begin
				wr_en   = alu_done;
				wr_addr = addr_next;
				wr_data = alu_result;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and stack count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (req_q == REQ_SWAP && !cnt_few) begin
						state_q <= S_SWAP;
					end else if (arith_go) begin
						state_q <= S_ALU;
					end else begin
						state_q <= S_OUT;
					end
					if (req_q == REQ_PUSH && !cnt_full) begin
						count_q <= count_q + ONE_CNT;
					end else if (req_q == REQ_DROP && !cnt_zero) begin
						count_q <= cnt_m1;
					end
				end
				S_SWAP: begin
					state_q <= S_OUT;
				end
				S_ALU: begin
					if (alu_done) begin
						count_q <= cnt_m1;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request capture, pending result and the output register.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q  <= req_type;
			opnd_q <= operand;
		end
		if (state_q == S_READ) begin
			res_stat_q <= ST_OK;
			res_top_q  <= cnt_zero ? '0 : rd_top;
			case (req_q)
				REQ_PUSH: begin
					if (cnt_full) begin
						res_stat_q <= ST_FULL;
					end else begin
						res_top_q <= opnd_q;
					end
				end
				REQ_DROP: begin
					res_top_q <= cnt_few ? '0 : rd_next;
				end
				REQ_PEEK: begin
					if (cnt_zero) begin
						res_stat_q <= ST_EMPTY;
					end
				end
				REQ_SWAP: begin
					if (cnt_few) begin
						res_stat_q <= ST_FEW;
					end else begin
						res_top_q <= rd_next;
					end
				end
				default: begin
					if (cnt_few) begin
						res_stat_q <= ST_FEW;
					end else if (req_q == REQ_DIV && rd_top == '0) begin
						res_stat_q <= ST_DIVZ;
					end
				end
			endcase
		end
		if (state_q == S_ALU && alu_done) begin
			res_top_q <= alu_result;
		end
		if (state_q == S_OUT && out_free) begin
			top_q    <= res_top_q;
			depth_q  <= 5'(count_q);
			status_q <= res_stat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign top_value = top_q;
	assign depth     = depth_q;
	assign status    = status_q;

endmodule

FILE: sv/rpnsc_stack.sv
module rpnsc_stack #(
	parameter int DEPTH = rpnsc_pkg::STACK_DEPTH_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  rpnsc_pkg::word_t     wr_data,
	input  logic [AW-1:0]        rd_addr_a,
	input  logic [AW-1:0]        rd_addr_b,
	output rpnsc_pkg::word_t     rd_data_a,
	output rpnsc_pkg::word_t     rd_data_b
);
	import rpnsc_pkg::*;

	word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

FILE: sv/rpnsc_alu.sv
module rpnsc_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  rpnsc_pkg::alu_req_t req,
	input  rpnsc_pkg::word_t   a,
	input  rpnsc_pkg::word_t   b,
	output logic               done,
	output rpnsc_pkg::word_t   result
);
	import rpnsc_pkg::*;

	localparam logic [1:0] A_IDLE = 2'd0;
	localparam logic [1:0] A_RUN  = 2'd1;
	localparam logic [1:0] A_FIX  = 2'd2;

	logic [1:0]        state_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic              mul_q;
	logic              neg_q;
	logic [WORD_W-1:0] x_q;
	logic [WORD_W-1:0] y_q;
	logic [WORD_W-1:0] acc_q;
	word_t             res_q;
	logic [WORD_W:0]   trial;
	logic [WORD_W-1:0] mag_a;
	logic [WORD_W-1:0] mag_b;

	assign mag_a = a[WORD_W-1] ? (WORD_W'(0) - WORD_W'(a)) : WORD_W'(a);
	assign mag_b = b[WORD_W-1] ? (WORD_W'(0) - WORD_W'(b)) : WORD_W'(b);
	assign trial = {acc_q, x_q[WORD_W-1]} - {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						cnt_q <= '0;
						if (req.op == REQ_MUL || req.op == REQ_DIV) begin
							state_q <= A_RUN;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				A_RUN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= A_FIX;
					end
				end
				A_FIX: begin
					done_q  <= 1'b1;
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				if (req.start) begin
					mul_q <= (req.op == REQ_MUL);
					neg_q <= a[WORD_W-1] ^ b[WORD_W-1];
					acc_q <= '0;
					case (req.op)
						REQ_ADD: res_q <= a + b;
						REQ_SUB: res_q <= a - b;
						REQ_MUL: begin
							x_q <= WORD_W'(a);
							y_q <= WORD_W'(b);
						end
						REQ_DIV: begin
							x_q <= mag_a;
							y_q <= mag_b;
						end
						default: res_q <= '0;
					endcase
				end
			end
			A_RUN: begin
				if (mul_q) begin
					// Shift-and-add: low bit of x selects the shifted multiplicand.
					if (x_q[0]) begin
						acc_q <= acc_q + y_q;
					end
					x_q <= x_q >> 1;
					y_q <= y_q << 1;
				end else begin
					// Restoring division: x shifts into the remainder, quotient bits shift in.
					if (!trial[WORD_W]) begin
						acc_q <= trial[WORD_W-1:0];
						x_q   <= {x_q[WORD_W-2:0], 1'b1};
					end else begin
						acc_q <= {acc_q[WORD_W-2:0], x_q[WORD_W-1]};
						x_q   <= {x_q[WORD_W-2:0], 1'b0};
					end
				end
			end
			A_FIX: begin
				if (mul_q) begin
					res_q <= word_t'(acc_q);
				end else if (neg_q) begin
					res_q <= word_t'(WORD_W'(0) - x_q);
				end else begin
					res_q <= word_t'(x_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import rpnsc_pkg::*;

	localparam int STACK_ENTRIES = STACK_DEPTH_DEF;
	localparam int BLOCK_LEN = 25;
	localparam int RANDOM_BLOCKS = 22;
	// The slowest requests are multiply and divide, and each side may add random idle gaps.
	// A silence as long as WATCHDOG_LIMIT without any transfer can only mean the block is stuck.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 60;
	localparam int REPORT_LIMIT = 10;

	localparam word_t MOST_NEG = word_t'(32'h8000_0000);
	localparam word_t MOST_POS = word_t'(32'h7FFF_FFFF);

	// How the random requests of one block are weighted.
	typedef enum int {
		MIX_BUILD,
		MIX_REDUCE,
		MIX_BALANCED
	} req_mix_t;

	// Top value, depth and status of one result, as one record.
	typedef struct packed {
		word_t      top;
		logic [4:0] depth;
		stat_code_t status;
	} calc_result_t;

	// This class keeps its own copy of the stack and predicts the result of each
	// request in the order the requests are accepted. Every result that comes out of
	// the block is compared with the oldest prediction that is still waiting.
	class calc_scoreboard;
		word_t        stack_mem[STACK_ENTRIES];
		int unsigned  entries;
		calc_result_t awaited_q[$];
		int unsigned  mismatches;
		int unsigned  results_checked;
		int unsigned  requests_taken;
		int unsigned  status_tally[5];

		function new();
			entries = 0;
			mismatches = 0;
			results_checked = 0;
			requests_taken = 0;
			foreach (status_tally[i])
				status_tally[i] = 0;
		endfunction

		// Signed division that truncates toward zero. Most negative over minus one
		// wraps back to the most negative value.
		function word_t trunc_quotient(word_t num, word_t den);
			logic [31:0] mag_num;
			logic [31:0] mag_den;
			logic [31:0] mag_q;
			mag_num = num[31] ? (~num + 32'd1) : num;
			mag_den = den[31] ? (~den + 32'd1) : den;
			mag_q = mag_num / mag_den;
			return (num[31] != den[31]) ? word_t'(~mag_q + 32'd1) : word_t'(mag_q);
		endfunction

		function void note_input(req_code_t op, word_t value);
			stat_code_t   st;
			word_t        rhs;
			word_t        lhs;
			word_t        res;
			calc_result_t predicted;
			st = ST_OK;
			requests_taken++;
			case (op)
				REQ_PUSH: begin
					if (entries >= STACK_ENTRIES) begin
						st = ST_FULL;
					end else begin
						stack_mem[entries] = value;
						entries++;
					end
				end
				REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV, REQ_SWAP: begin
					if (entries < 2) begin
						st = ST_FEW;
					end else begin
						rhs = stack_mem[entries - 1];
						lhs = stack_mem[entries - 2];
						if (op == REQ_SWAP) begin
							stack_mem[entries - 1] = lhs;
							stack_mem[entries - 2] = rhs;
						end else if (op == REQ_DIV && rhs == '0) begin
							st = ST_DIVZ;
						end else begin
							case (op)
								REQ_ADD: res = lhs + rhs;
								REQ_SUB: res = lhs - rhs;
								REQ_MUL: res = lhs * rhs;
								default: res = trunc_quotient(lhs, rhs);
							endcase
							entries--;
							stack_mem[entries - 1] = res;
						end
					end
				end
				REQ_DROP: begin
					if (entries > 0)
						entries--;
				end
				default: begin
					if (entries == 0)
						st = ST_EMPTY;
				end
			endcase
			predicted.top = (entries > 0) ? stack_mem[entries - 1] : '0;
			predicted.depth = 5'(entries);
			predicted.status = st;
			awaited_q.push_back(predicted);
		endfunction

		function void check_result(word_t top, logic [4:0] dep, stat_code_t st);
			calc_result_t want;
			results_checked++;
			if (st < 5)
				status_tally[st]++;
			if (awaited_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("Unexpected result: top %0d depth %0d status %0d", top, dep, st);
				return;
			end
			want = awaited_q.pop_front();
			if (want.top !== top || want.depth !== dep || want.status !== st) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("Mismatch on result %0d: expected top %0d depth %0d status %0d, got top %0d depth %0d status %0d",
						results_checked, want.top, want.depth, want.status, top, dep, st);
			end
		endfunction

		function int unsigned pending();
			return awaited_q.size();
		endfunction

		function bit failed();
			return (mismatches != 0) || (awaited_q.size() != 0);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	req_code_t  req_type = REQ_PUSH;
	word_t      operand = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	word_t      top_value;
	logic [4:0] depth;
	stat_code_t status;

	// While calm is set, neither side inserts idle cycles, so back-to-back
	// transfers are exercised as well.
	bit          calm = 1'b0;
	int unsigned idle_cycles = 0;

	calc_scoreboard book = new();

	always #5 clk = ~clk;

	rpn_stack_calculator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.operand   (operand),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.top_value (top_value),
		.depth     (depth),
		.status    (status)
	);

	// Offers one request after a random gap and holds it until the transfer
	// happens. The prediction is made at the edge where the request is taken.
	// When the gap is zero, valid simply stays high and only the payload changes.
	task automatic send_request(req_code_t op, word_t value);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		operand <= value;
		do
			@(posedge clk);
		while (!in_ready);
		book.note_input(op, value);
	endtask

	// Operands lean toward the values that matter for wrapping and division:
	// zero, one, minus one and both extremes. The rest are small or fully random.
	function automatic word_t pick_operand();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return word_t'(1);
			2: return word_t'(-1);
			3: return MOST_NEG;
			4: return MOST_POS;
			5, 6: return word_t'(int'($urandom_range(0, 40)) - 20);
			default: return word_t'($urandom());
		endcase
	endfunction

	// A build block is mostly pushes and drives the stack up to full and beyond.
	// A reduce block is mostly operations and folds the stack down, so
	// expressions get evaluated and the too-few cases come up once it is empty.
	function automatic req_code_t pick_request(req_mix_t mix, int unsigned entries);
		int unsigned push_odds;
		case (mix)
			MIX_BUILD:  push_odds = 7;
			MIX_REDUCE: push_odds = 1;
			default:    push_odds = (entries < 4) ? 4 : 3;
		endcase
		if ($urandom_range(0, 7) < push_odds)
			return REQ_PUSH;
		return req_code_t'($urandom_range(1, 7));
	endfunction

	// Counts the cycles since the last transfer on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// If neither channel moves for too long, the block is stuck and the run ends here.
	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("Timeout: no transfer for %0d cycles, %0d results still awaited",
			WATCHDOG_LIMIT, book.pending());
		$display("RESULT: ERROR");
		$finish;
	end

	// The receiving side stalls for a random number of cycles before each result,
	// then takes the result and checks it.
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			book.check_result(top_value, depth, status);
		end
	end

	initial begin
		req_mix_t mix;
		req_code_t op;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests. The stack starts empty, so peek reports empty, drop
		// does nothing, and operations with fewer than two entries are refused
		// (the too-few check comes ahead of the divide-by-zero check).
		send_request(REQ_PEEK, '0);
		send_request(REQ_DROP, '0);
		send_request(REQ_ADD, '0);
		send_request(REQ_PUSH, MOST_POS);
		send_request(REQ_SUB, '0);
		send_request(REQ_SWAP, '0);
		send_request(REQ_DIV, '0);
		// The largest value plus one wraps around to the most negative value.
		send_request(REQ_PUSH, word_t'(1));
		send_request(REQ_ADD, '0);
		// Two swaps give back the original order. Then the most negative value
		// divided by minus one wraps back to itself.
		send_request(REQ_PUSH, word_t'(-1));
		send_request(REQ_SWAP, '0);
		send_request(REQ_SWAP, '0);
		send_request(REQ_DIV, '0);
		// A zero divisor leaves the stack as it is.
		send_request(REQ_PUSH, '0);
		send_request(REQ_DIV, '0);
		send_request(REQ_DROP, '0);
		// Negative operands in division truncate toward zero.
		send_request(REQ_PUSH, word_t'(-7));
		send_request(REQ_DIV, '0);
		send_request(REQ_PUSH, word_t'(3));
		send_request(REQ_MUL, '0);
		send_request(REQ_PUSH, word_t'(32'h0F0F_0F0F));
		send_request(REQ_SUB, '0);
		send_request(REQ_PEEK, '0);
		// This product overflows and keeps only its low 32 bits.
		send_request(REQ_PUSH, MOST_POS);
		send_request(REQ_MUL, '0);
		send_request(REQ_DROP, '0);

		// Random requests in blocks. The first block builds the stack past full,
		// the second folds it back down, and after that the mix is random.
		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			if (blk == 0)
				mix = MIX_BUILD;
			else if (blk == 1)
				mix = MIX_REDUCE;
			else
				mix = req_mix_t'($urandom_range(0, 2));
			calm = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < BLOCK_LEN; n++) begin
				op = pick_request(mix, book.entries);
				send_request(op, pick_operand());
			end
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		// Wait for every result that is still due, then give the block some time
		// to show any extra result it should not send.
		while (book.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results for %0d requests, with directed corner cases and %0d random blocks.",
			book.results_checked, book.requests_taken, RANDOM_BLOCKS);
		$display("Status counts: ok %0d, too few %0d, divide by zero %0d, full %0d, empty %0d; mismatches %0d.",
			book.status_tally[ST_OK], book.status_tally[ST_FEW], book.status_tally[ST_DIVZ],
			book.status_tally[ST_FULL], book.status_tally[ST_EMPTY], book.mismatches);
		if (book.failed())
			$display("RESULT: ERROR");
		else
			$display("RESULT: OK");
		$finish;
	end

endmodule
